// ===== hdl/bdac_pkg.sv =====
package bdac_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CHAR_WIDTH = 6;
   localparam int DIGIT_WIDTH = 4;

   localparam int MAX_DIGITS_DEFAULT = 10;
   localparam int MAX_DIGITS_LIMIT = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_WIDTH-1:0] ADJUST_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] ADJUST_ADD = 4'd3;

   typedef enum logic [1:0] {
      BDAC_IDLE,
      BDAC_SHIFT,
      BDAC_EMIT
   } state_type;

   // one queued word as seen by the back end
   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] value;
   } item_type;

endpackage

// ===== hdl/binary_to_decimal_ascii_core.sv =====
// The back end converts one word at a time: it takes the next queued word only after the
// last character of the previous word has gone into the result register.
// Each conversion runs the 32-step double-dabble shift loop, then the emit/skip stage, which
// advances one digit a cycle; a digit to emit waits while the result register is still full.
// Reset (synchronous, active high) empties the input queue and the result register.
module binary_to_decimal_ascii_core #(
   parameter int MAX_DIGITS  = bdac_pkg::MAX_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH = bdac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [bdac_pkg::DATA_WIDTH-1:0] req_value,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [bdac_pkg::CHAR_WIDTH-1:0] rsp_digit_char,
   output logic                            rsp_last
);

   bdac_pkg::item_type q_item;
   logic               q_take;

   // front end: hold incoming words so the host need not wait for a conversion
   bdac_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .item      (q_item),
      .take      (q_take)
   );

   // back end: shift-and-add-three conversion, then advance one digit a cycle (an emitted digit
   // waits for a free result register), dropping leading zeros and presenting each character in a result register
   bdac_back #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item           (q_item),
      .take           (q_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_char_is_digit: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_digit_char >= bdac_pkg::ASCII_ZERO) &&
                     (rsp_digit_char <= bdac_pkg::ASCII_ZERO + 6'd9))
      else $error("result character is not a decimal digit");

   a_take_needs_word: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_item.valid)
      else $error("back end took a word from an empty queue");
`endif

endmodule

// ===== hdl/bdac_queue.sv =====
module bdac_queue #(
   parameter int DEPTH = bdac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic [bdac_pkg::DATA_WIDTH-1:0] req_value,
   output logic                            req_full,
   output bdac_pkg::item_type              item,
   input  logic                            take
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [bdac_pkg::DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;

   assign req_full   = (count_ff == CNT_W'(DEPTH));
   assign push_ok    = req_push && !req_full;
   assign item.valid = (count_ff != '0);
   assign item.value = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !take) begin
         count_in = count_ff + CNT_W'(1);
      end else if (take && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= req_value;
      end
   end

endmodule

// ===== hdl/bdac_back.sv =====
module bdac_back #(
   parameter int MAX_DIGITS = bdac_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bdac_pkg::item_type              item,
   output logic                            take,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [bdac_pkg::CHAR_WIDTH-1:0] rsp_digit_char,
   output logic                            rsp_last
);

   // clamp the digit register count to the supported range
   localparam int DIGITS      = (MAX_DIGITS < 1) ? 1 :
                                ((MAX_DIGITS > bdac_pkg::MAX_DIGITS_LIMIT) ?
                                 bdac_pkg::MAX_DIGITS_LIMIT : MAX_DIGITS);
   localparam int DW          = bdac_pkg::DIGIT_WIDTH;
   localparam int BCD_W       = DW * DIGITS;
   localparam int SHIFT_W     = $clog2(bdac_pkg::DATA_WIDTH);
   localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

   bdac_pkg::state_type state_ff, state_in;

   logic [bdac_pkg::DATA_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]                bcd_ff, bcd_in, bcd_adj;
   logic [SHIFT_W-1:0]              shift_cnt_ff, shift_cnt_in;
   logic [DIGIT_CNT_W-1:0]          dig_cnt_ff, dig_cnt_in;
   logic                            started_ff, started_in;
   logic                            out_valid_ff, out_valid_in;
   logic [bdac_pkg::CHAR_WIDTH-1:0] out_char_ff, out_char_in;
   logic                            out_last_ff, out_last_in;

   logic [DW-1:0] top_digit;
   logic          out_free;
   logic          skip;
   logic          final_digit;
   logic          shift_done;

   assign top_digit   = bcd_ff[BCD_W-1 -: DW];
   assign out_free    = !out_valid_ff || rsp_pop;
   assign final_digit = (dig_cnt_ff == DIGIT_CNT_W'(1));
   assign skip        = !started_ff && (top_digit == '0) && !final_digit;
   assign shift_done  = (shift_cnt_ff == SHIFT_W'(bdac_pkg::DATA_WIDTH - 1));

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;

   // add three to every digit of five or more ahead of the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[DW*i +: DW] = (bcd_ff[DW*i +: DW] >= bdac_pkg::ADJUST_LIMIT)
                             ? bcd_ff[DW*i +: DW] + bdac_pkg::ADJUST_ADD
                             : bcd_ff[DW*i +: DW];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdac_pkg::BDAC_IDLE: begin
            if (item.valid) state_in = bdac_pkg::BDAC_SHIFT;
         end
         bdac_pkg::BDAC_SHIFT: begin
            if (shift_done) state_in = bdac_pkg::BDAC_EMIT;
         end
         bdac_pkg::BDAC_EMIT: begin
            if (!skip && out_free && final_digit) state_in = bdac_pkg::BDAC_IDLE;
         end
         default: state_in = bdac_pkg::BDAC_IDLE;
      endcase
   end

   always_comb begin
      take         = 1'b0;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      shift_cnt_in = shift_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         bdac_pkg::BDAC_IDLE: begin
            if (item.valid) begin
               take         = 1'b1;
               bin_in       = item.value;
               bcd_in       = '0;
               shift_cnt_in = '0;
            end
         end
         bdac_pkg::BDAC_SHIFT: begin
            bcd_in       = {bcd_adj[BCD_W-2:0], bin_ff[bdac_pkg::DATA_WIDTH-1]};
            bin_in       = {bin_ff[bdac_pkg::DATA_WIDTH-2:0], 1'b0};
            shift_cnt_in = shift_cnt_ff + SHIFT_W'(1);
            dig_cnt_in   = DIGIT_CNT_W'(DIGITS);
            started_in   = 1'b0;
         end
         bdac_pkg::BDAC_EMIT: begin
            if (skip) begin
               // drop a leading zero
               bcd_in     = bcd_ff << DW;
               dig_cnt_in = dig_cnt_ff - DIGIT_CNT_W'(1);
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = bdac_pkg::ASCII_ZERO + {{(bdac_pkg::CHAR_WIDTH - DW){1'b0}},
                                                      top_digit};
               out_last_in  = final_digit;
               started_in   = 1'b1;
               bcd_in       = bcd_ff << DW;
               dig_cnt_in   = dig_cnt_ff - DIGIT_CNT_W'(1);
            end
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdac_pkg::BDAC_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      shift_cnt_ff <= shift_cnt_in;
      dig_cnt_ff   <= dig_cnt_in;
      started_ff   <= started_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

endmodule
